>>> hw/rtl/epv_pkg.sv
package epv_pkg;

  localparam int INDEX_BITS = 16;
  localparam int OUT_BITS   = INDEX_BITS + 1;
  localparam int TOPO_BITS  = 4;

  // remainder pipeline: two dividend bits resolved per stage
  localparam int REM_RADIX_BITS = 2;
  localparam int REM_STAGES     = (OUT_BITS + REM_RADIX_BITS - 1) / REM_RADIX_BITS;
  localparam int NUM_BITS       = REM_STAGES * REM_RADIX_BITS;

  // divide by three as multiply by rounded-up reciprocal
  localparam int DIV3_SHIFT = INDEX_BITS + 1;
  localparam logic [INDEX_BITS:0] DIV3_MUL =
    (INDEX_BITS + 1)'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

  localparam logic [TOPO_BITS-1:0] TOPO_POINTS     = 4'd0;
  localparam logic [TOPO_BITS-1:0] TOPO_LINES      = 4'd1;
  localparam logic [TOPO_BITS-1:0] TOPO_LINE_STRIP = 4'd2;
  localparam logic [TOPO_BITS-1:0] TOPO_LINE_LOOP  = 4'd3;
  localparam logic [TOPO_BITS-1:0] TOPO_POLYGON    = 4'd4;
  localparam logic [TOPO_BITS-1:0] TOPO_TRIANGLES  = 4'd5;
  localparam logic [TOPO_BITS-1:0] TOPO_TRI_STRIP  = 4'd6;
  localparam logic [TOPO_BITS-1:0] TOPO_TRI_FAN    = 4'd7;
  localparam logic [TOPO_BITS-1:0] TOPO_QUADS      = 4'd8;
  localparam logic [TOPO_BITS-1:0] TOPO_QUAD_STRIP = 4'd9;

  localparam logic CFG_TOPOLOGY     = 1'b0;
  localparam logic CFG_VERTEX_TOTAL = 1'b1;

  typedef struct packed {
    logic [OUT_BITS-1:0]   first;
    logic [OUT_BITS-1:0]   second;
    logic [OUT_BITS-1:0]   count;
    logic                  wrap;
    logic [NUM_BITS-1:0]   num;
    logic [INDEX_BITS-1:0] rem;
  } epv_item_t;

  function automatic logic [INDEX_BITS-1:0] div3(input logic [INDEX_BITS-1:0] x);
    logic [2*INDEX_BITS:0] prod;
    prod = {{INDEX_BITS{1'b0}}, x} * {{INDEX_BITS{1'b0}}, DIV3_MUL};
    return prod[2*INDEX_BITS:DIV3_SHIFT];
  endfunction

endpackage

>>> hw/rtl/primitive_edge_vertex_pair_top.sv
// channel | dir | ports                                              | moves
// in      | in  | in_valid, in_ready, in_edge_number                  | one edge index per word
// out     | out | out_valid, out_ready, out_first_vertex,            | one vertex pair and the
//         |     | out_second_vertex, out_edges_in_list               | edge count per word
// cfg     | in  | cfg_valid, cfg_ready, cfg_index, cfg_data          | one register write
//
// one word accepted per cycle when the output side keeps up
// 2 + REM_STAGES (11) register stages: input register, index arithmetic register, then the
// nine-stage remainder pipeline that wraps the loop and polygon second vertex; a word taken
// moves through these registers in that order to the output, advancing only while en is high
// a stalled output word freezes the whole pipeline; in_ready = !out_valid || out_ready
// synchronous active-low reset clears all valid flags and both config registers
module primitive_edge_vertex_pair_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [epv_pkg::INDEX_BITS-1:0] in_edge_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [epv_pkg::OUT_BITS-1:0]   out_first_vertex,
  output logic [epv_pkg::OUT_BITS-1:0]   out_second_vertex,
  output logic [epv_pkg::OUT_BITS-1:0]   out_edges_in_list,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [epv_pkg::INDEX_BITS-1:0] cfg_data
);
  import epv_pkg::*;

  logic [TOPO_BITS-1:0]  topology_r;
  logic [INDEX_BITS-1:0] vertex_total_r;
  logic                  in_valid_r;
  logic [INDEX_BITS-1:0] in_edge_r;
  logic                  calc_valid_r;
  epv_item_t             calc_item_r;
  epv_item_t             calc_item_nxt;
  logic                  en;
  logic [REM_STAGES:0]   stage_valid;
  epv_item_t             stage_item [REM_STAGES+1];
  epv_item_t             last_item;
  logic [REM_STAGES+2:0] all_valid;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topology_r     <= TOPO_POINTS;
      vertex_total_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOPOLOGY:     topology_r     <= cfg_data[TOPO_BITS-1:0];
        CFG_VERTEX_TOTAL: vertex_total_r <= cfg_data;
        default:          topology_r     <= topology_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      calc_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r   <= in_valid;
      calc_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_edge_r   <= in_edge_number;
      calc_item_r <= calc_item_nxt;
    end
  end

  epv_calc u_calc (
    .topology     (topology_r),
    .vertex_total (vertex_total_r),
    .edge_number  (in_edge_r),
    .item         (calc_item_nxt)
  );

  assign stage_valid[0] = calc_valid_r;
  assign stage_item[0]  = calc_item_r;

  for (genvar g = 0; g < REM_STAGES; g++) begin : g_rem
    epv_rem_stage u_stage (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (en),
      .vertex_total (vertex_total_r),
      .in_valid     (stage_valid[g]),
      .in_item      (stage_item[g]),
      .out_valid    (stage_valid[g+1]),
      .out_item     (stage_item[g+1])
    );
  end

  assign last_item         = stage_item[REM_STAGES];
  assign out_valid         = stage_valid[REM_STAGES];
  assign out_first_vertex  = last_item.first;
  assign out_second_vertex = last_item.wrap ? {1'b0, last_item.rem} : last_item.second;
  assign out_edges_in_list = last_item.count;

  assign all_valid = {stage_valid, calc_valid_r, in_valid_r};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output word stalled");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(all_valid))
    else $error("pipeline moved during stall");

  a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_item.wrap |-> out_second_vertex < {1'b0, vertex_total_r})
    else $error("wrapped second vertex not below vertex total");

  a_wrap_topology: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_item.wrap |->
      (topology_r == TOPO_LINE_LOOP || topology_r == TOPO_POLYGON))
    else $error("wrap flag on a topology without wrap");

endmodule

>>> hw/rtl/epv_calc.sv
module epv_calc (
  input  logic [epv_pkg::TOPO_BITS-1:0]  topology,
  input  logic [epv_pkg::INDEX_BITS-1:0] vertex_total,
  input  logic [epv_pkg::INDEX_BITS-1:0] edge_number,
  output epv_pkg::epv_item_t             item
);
  import epv_pkg::*;

  logic [OUT_BITS-1:0]   i_x;
  logic [OUT_BITS-1:0]   i_inc;
  logic [OUT_BITS-1:0]   v_x;
  logic [INDEX_BITS-1:0] i_dec;
  logic [INDEX_BITS-1:0] q3;
  logic [INDEX_BITS-1:0] r3_full;
  logic [1:0]            m3;
  logic [INDEX_BITS-1:0] v3;
  logic [INDEX_BITS-1:0] face_s;
  logic [INDEX_BITS-1:0] face_q;
  logic [OUT_BITS-1:0]   face_s_x;
  logic [OUT_BITS-1:0]   face_q2;
  logic [1:0]            m3_prev;
  logic [1:0]            quad_low;
  logic                  odd;

  assign i_x      = {1'b0, edge_number};
  assign i_inc    = i_x + OUT_BITS'(1);
  assign v_x      = {1'b0, vertex_total};
  assign i_dec    = edge_number - INDEX_BITS'(1);
  assign q3       = div3(edge_number);
  assign r3_full  = edge_number - {q3[INDEX_BITS-2:0], 1'b0} - q3;
  assign m3       = r3_full[1:0];
  assign v3       = div3(vertex_total);
  assign odd      = edge_number[0];
  assign face_s   = {1'b0, i_dec[INDEX_BITS-1:1]};
  assign face_s_x = {1'b0, face_s};
  // quad strip face is (i-1)/3, one below i/3 when i lands on a multiple of three
  assign face_q   = (m3 == 2'd0) ? q3 - INDEX_BITS'(1) : q3;
  assign face_q2  = {face_q, 1'b0};
  assign m3_prev  = (m3 == 2'd0) ? 2'd2 : m3 - 2'd1;
  assign quad_low = edge_number[1:0] + 2'd1;

  always_comb begin
    item       = '0;
    item.num   = {{(NUM_BITS-OUT_BITS){1'b0}}, i_inc};
    case (topology)
      TOPO_POINTS: begin
        item.first  = i_x;
        item.second = i_x;
        item.count  = '0;
      end
      TOPO_LINES: begin
        item.first  = {edge_number, 1'b0};
        item.second = {edge_number, 1'b1};
        item.count  = v_x >> 1;
      end
      TOPO_LINE_STRIP: begin
        item.first  = i_x;
        item.second = i_inc;
        item.count  = (vertex_total != '0) ? v_x - OUT_BITS'(1) : '0;
      end
      TOPO_LINE_LOOP, TOPO_POLYGON: begin
        item.first  = i_x;
        item.second = i_inc;
        item.wrap   = (vertex_total != '0);
        item.count  = v_x;
      end
      TOPO_TRIANGLES: begin
        item.first  = i_x;
        item.second = {1'b0, edge_number - {{(INDEX_BITS-2){1'b0}}, m3}}
                    + ((m3 == 2'd2) ? OUT_BITS'(0) : OUT_BITS'(m3) + OUT_BITS'(1));
        item.count  = {1'b0, v3};
      end
      TOPO_TRI_STRIP: begin
        if (edge_number == '0) begin
          item.first  = OUT_BITS'(0);
          item.second = OUT_BITS'(1);
        end else begin
          item.first  = face_s_x + (odd ? OUT_BITS'(!face_s[0]) : OUT_BITS'(2));
          item.second = face_s_x + (odd ? OUT_BITS'(2) : OUT_BITS'(face_s[0]));
        end
        item.count = v_x - {1'b0, v3} + OUT_BITS'(1);
      end
      TOPO_TRI_FAN: begin
        if (edge_number == '0) begin
          item.first  = OUT_BITS'(0);
          item.second = OUT_BITS'(1);
        end else begin
          item.first  = face_s_x + OUT_BITS'(2) - OUT_BITS'(odd);
          item.second = odd ? face_s_x + OUT_BITS'(2) : OUT_BITS'(0);
        end
        item.count = v_x - {1'b0, v3} + OUT_BITS'(1);
      end
      TOPO_QUADS: begin
        item.first  = i_x;
        item.second = {1'b0, edge_number[INDEX_BITS-1:2], quad_low};
        item.count  = v_x >> 2;
      end
      TOPO_QUAD_STRIP: begin
        if (edge_number == '0) begin
          item.first  = OUT_BITS'(0);
          item.second = OUT_BITS'(1);
        end else begin
          item.first  = face_q2 + OUT_BITS'(m3) + OUT_BITS'(m3_prev);
          item.second = face_q2
                      + ((m3 == 2'd0) ? OUT_BITS'(0) : OUT_BITS'(3'd4 - {1'b0, m3}));
        end
        item.count = v_x - (v_x >> 2) + OUT_BITS'(1);
      end
      default: begin
        item.first  = '0;
        item.second = '0;
        item.count  = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/epv_rem_stage.sv
module epv_rem_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [epv_pkg::INDEX_BITS-1:0] vertex_total,
  input  logic                           in_valid,
  input  epv_pkg::epv_item_t             in_item,
  output logic                           out_valid,
  output epv_pkg::epv_item_t             out_item
);
  import epv_pkg::*;

  logic                valid_r;
  epv_item_t           item_r;
  epv_item_t           item_nxt;
  logic [INDEX_BITS:0] div_x;
  logic [INDEX_BITS:0] part;
  int                  k;

  assign div_x = {1'b0, vertex_total};

  // restoring remainder, one dividend bit per step, msb first
  always_comb begin
    item_nxt = in_item;
    for (k = 0; k < REM_RADIX_BITS; k++) begin
      part = {item_nxt.rem, item_nxt.num[NUM_BITS-1]};
      if (part >= div_x) begin
        part = part - div_x;
      end
      item_nxt.rem = part[INDEX_BITS-1:0];
      item_nxt.num = {item_nxt.num[NUM_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import epv_pkg::*;

  localparam int LATENCY    = 2 + REM_STAGES;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_WORDS = 300;
  localparam logic [TOPO_BITS-1:0] TOPO_BAD_LO = 4'd10;
  localparam logic [TOPO_BITS-1:0] TOPO_BAD_HI = 4'd15;

  typedef struct packed {
    logic [OUT_BITS-1:0] first;
    logic [OUT_BITS-1:0] second;
    logic [OUT_BITS-1:0] count;
  } vertex_pair_t;

  typedef struct packed {
    logic [TOPO_BITS-1:0]  topo;
    logic [INDEX_BITS-1:0] vtot;
    logic [INDEX_BITS-1:0] idx;
    logic                  typed;
    vertex_pair_t          pair;
  } edge_case_t;

  localparam int N_DIR = 25;
  // rows with typed set carry a hand-read result, the rest go through edge_ends
  edge_case_t dir_tbl [N_DIR] = '{
    '{TOPO_POINTS,     16'd0,     16'd0,     1'b1, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_POINTS,     16'd65535, 16'd65535, 1'b1, '{17'd65535,  17'd65535,  17'd0}},
    '{TOPO_LINES,      16'd65535, 16'd65535, 1'b1, '{17'd131070, 17'd131071, 17'd32767}},
    '{TOPO_LINE_STRIP, 16'd0,     16'd5,     1'b1, '{17'd5,      17'd6,      17'd0}},
    '{TOPO_LINE_STRIP, 16'd65535, 16'd65535, 1'b1, '{17'd65535,  17'd65536,  17'd65534}},
    '{TOPO_LINE_LOOP,  16'd0,     16'd65535, 1'b1, '{17'd65535,  17'd65536,  17'd0}},
    '{TOPO_LINE_LOOP,  16'd10,    16'd9,     1'b1, '{17'd9,      17'd0,      17'd10}},
    '{TOPO_POLYGON,    16'd65535, 16'd65534, 1'b1, '{17'd65534,  17'd0,      17'd65535}},
    '{TOPO_POLYGON,    16'd65535, 16'd65535, 1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_POLYGON,    16'd1,     16'd0,     1'b1, '{17'd0,      17'd0,      17'd1}},
    '{TOPO_TRIANGLES,  16'd65535, 16'd65535, 1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_TRIANGLES,  16'd6,     16'd2,     1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_TRI_STRIP,  16'd0,     16'd0,     1'b1, '{17'd0,      17'd1,      17'd1}},
    '{TOPO_TRI_STRIP,  16'd0,     16'd1,     1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_TRI_STRIP,  16'd0,     16'd2,     1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_TRI_STRIP,  16'd0,     16'd65535, 1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_TRI_FAN,    16'd0,     16'd0,     1'b1, '{17'd0,      17'd1,      17'd1}},
    '{TOPO_TRI_FAN,    16'd0,     16'd3,     1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_TRI_FAN,    16'd0,     16'd65535, 1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_QUADS,      16'd65535, 16'd65535, 1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_QUAD_STRIP, 16'd8,     16'd0,     1'b1, '{17'd0,      17'd1,      17'd7}},
    '{TOPO_QUAD_STRIP, 16'd8,     16'd4,     1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_QUAD_STRIP, 16'd8,     16'd65535, 1'b0, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_BAD_LO,     16'd100,   16'd7,     1'b1, '{17'd0,      17'd0,      17'd0}},
    '{TOPO_BAD_HI,     16'd65535, 16'd65535, 1'b1, '{17'd0,      17'd0,      17'd0}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [INDEX_BITS-1:0] in_edge_number = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_BITS-1:0]   out_first_vertex;
  logic [OUT_BITS-1:0]   out_second_vertex;
  logic [OUT_BITS-1:0]   out_edges_in_list;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_TOPOLOGY;
  logic [INDEX_BITS-1:0] cfg_data = '0;

  logic [TOPO_BITS-1:0]  cur_topo = TOPO_POINTS;
  logic [INDEX_BITS-1:0] cur_vtot = '0;
  vertex_pair_t          pending_pairs [$];
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    errors = 0;
  int                    words_sent = 0;
  int                    words_checked = 0;
  int                    reg_writes = 0;
  int                    cycles = 0;
  logic [15:0]           topos_seen = '0;

  primitive_edge_vertex_pair_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_edge_number    (in_edge_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_vertex  (out_first_vertex),
    .out_second_vertex (out_second_vertex),
    .out_edges_in_list (out_edges_in_list),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // endpoints and edge count for one edge index under the given topology
  function automatic vertex_pair_t edge_ends(input logic [TOPO_BITS-1:0] topo,
                                             input logic [INDEX_BITS-1:0] vtot,
                                             input logic [INDEX_BITS-1:0] idx);
    longint unsigned i, v, a, b, n, face, odd, m;
    vertex_pair_t r;
    i = idx;
    v = vtot;
    a = 0;
    b = 0;
    n = 0;
    case (topo)
      TOPO_POINTS: begin
        a = i;
        b = i;
      end
      TOPO_LINES: begin
        a = i * 2;
        b = i * 2 + 1;
        n = v / 2;
      end
      TOPO_LINE_STRIP: begin
        a = i;
        b = i + 1;
        n = (v > 0) ? v - 1 : 0;
      end
      TOPO_LINE_LOOP, TOPO_POLYGON: begin
        a = i;
        b = (v != 0) ? (i + 1) % v : i + 1;
        n = v;
      end
      TOPO_TRIANGLES: begin
        a = i;
        b = i / 3 * 3 + (i + 1) % 3;
        n = v / 3;
      end
      TOPO_TRI_STRIP: begin
        n = v - v / 3 + 1;
        if (i == 0) begin
          b = 1;
        end else begin
          face = (i - 1) / 2;
          odd  = i & 1;
          a = face + (odd != 0 ? ((face & 1) != 0 ? 0 : 1) : 2);
          b = face + (odd != 0 ? 2 : (face & 1));
        end
      end
      TOPO_TRI_FAN: begin
        n = v - v / 3 + 1;
        if (i == 0) begin
          b = 1;
        end else begin
          face = (i - 1) / 2;
          odd  = i & 1;
          a = face + 2 - odd;
          b = (odd != 0) ? face + 2 : 0;
        end
      end
      TOPO_QUADS: begin
        a = i;
        b = i / 4 * 4 + (i + 1) % 4;
        n = v / 4;
      end
      TOPO_QUAD_STRIP: begin
        n = v - v / 4 + 1;
        if (i == 0) begin
          b = 1;
        end else begin
          face = (i - 1) / 3;
          m = i % 3;
          a = face * 2 + m + (i + 2) % 3;
          b = face * 2 + ((m == 0) ? 0 : 4 - m);
        end
      end
      default: ;
    endcase
    r.first  = a[OUT_BITS-1:0];
    r.second = b[OUT_BITS-1:0];
    r.count  = n[OUT_BITS-1:0];
    return r;
  endfunction

  task automatic write_reg(input logic idx, input logic [INDEX_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    if (idx == CFG_TOPOLOGY) cur_topo = data[TOPO_BITS-1:0];
    else                     cur_vtot = data;
  endtask

  // only called with nothing in flight
  task automatic set_topology(input logic [TOPO_BITS-1:0] topo,
                              input logic [INDEX_BITS-1:0] vtot);
    logic [INDEX_BITS-1:0] word;
    word = {INDEX_BITS{1'b0}};
    word[TOPO_BITS-1:0] = topo;
    // unused upper bits get random junk half the time
    if ($urandom_range(1) == 1)
      word[INDEX_BITS-1:TOPO_BITS] = (INDEX_BITS - TOPO_BITS)'(
        $urandom_range((1 << (INDEX_BITS - TOPO_BITS)) - 1));
    write_reg(CFG_TOPOLOGY, word);
    write_reg(CFG_VERTEX_TOTAL, vtot);
    @(negedge clk);
    cfg_valid <= 1'b0;
    topos_seen[topo] = 1'b1;
  endtask

  task automatic send_edge(input logic [INDEX_BITS-1:0] idx, input vertex_pair_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_edge_number <= idx;
    do @(posedge clk); while (!in_ready);
    pending_pairs = {pending_pairs, want};
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_pairs.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin : check_out
    vertex_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result word: %0d %0d %0d", out_first_vertex,
               out_second_vertex, out_edges_in_list);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        words_checked++;
        if (out_first_vertex !== want.first) begin
          $error("first_vertex: expected %0d, actual %0d", want.first, out_first_vertex);
          errors++;
        end
        if (out_second_vertex !== want.second) begin
          $error("second_vertex: expected %0d, actual %0d", want.second, out_second_vertex);
          errors++;
        end
        if (out_edges_in_list !== want.count) begin
          $error("edges_in_list: expected %0d, actual %0d", want.count, out_edges_in_list);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [TOPO_BITS-1:0]  topo;
    logic [INDEX_BITS-1:0] vtot;
    logic [INDEX_BITS-1:0] idx;
    vertex_pair_t          want;
    longint unsigned       span;
    int                    sent, seg_len;
    send_idle_pct = 25;
    recv_idle_pct = 66;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows; first row runs on the reset settings
    topos_seen[TOPO_POINTS] = 1'b1;
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_tbl[r].topo != cur_topo || dir_tbl[r].vtot != cur_vtot) begin
        wait_drained();
        set_topology(dir_tbl[r].topo, dir_tbl[r].vtot);
      end
      want = dir_tbl[r].typed ? dir_tbl[r].pair
                              : edge_ends(cur_topo, cur_vtot, dir_tbl[r].idx);
      send_edge(dir_tbl[r].idx, want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 25 : 0;
      sent = 0;
      while (sent < RAND_WORDS) begin
        topo = ($urandom_range(9) < 8) ? TOPO_BITS'($urandom_range(9))
                                       : TOPO_BITS'($urandom_range(15, 10));
        case ($urandom_range(9))
          6:       vtot = '0;
          7:       vtot = '1;
          8, 9:    vtot = INDEX_BITS'($urandom_range(65535));
          default: vtot = INDEX_BITS'($urandom_range(24));
        endcase
        // every segment starts from an empty pipeline
        wait_drained();
        set_topology(topo, vtot);
        span = edge_ends(topo, vtot, '0).count;
        span = (span + 3 > 65535) ? 65535 : span + 3;
        seg_len = $urandom_range(40, 10);
        for (int k = 0; k < seg_len; k++) begin
          case ($urandom_range(9))
            0, 1:    idx = INDEX_BITS'($urandom_range(65535));
            2:       idx = '1;
            3:       idx = INDEX_BITS'($urandom_range(15));
            default: idx = INDEX_BITS'($urandom_range(int'(span)));
          endcase
          send_edge(idx, edge_ends(cur_topo, cur_vtot, idx));
        end
        sent += seg_len;
      end
    end

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    $display("sent %0d edge words, checked %0d results, %0d register writes",
             words_sent, words_checked, reg_writes);
    $display("topology codes exercised (bit per code): %b", topos_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
